### hw/rtl/ffha_pkg.sv
// Shared constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int unsigned RegW = 11;
  localparam int unsigned NbW = 14;
  localparam int unsigned AdrW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHeapLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinGrow = 1'b1;
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;
  localparam int unsigned InitBreak = 64;
  localparam int unsigned QuickMin = 2;
endpackage

### hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator over 16-byte units with quick lists; operations run as reads
// and writes on the header memory. After reset the header memory is cleared and seeded,
// and no word is accepted until that is done. A word is taken only while the block is
// idle and no result is waiting. A zero-size allocate returns a failed result, a quick-list
// hit takes the head block of its list, and a first-fit allocate reads the block headers
// on the walk (the sentinel included). A free outside the heap is dropped in the accepting
// cycle; other frees go to a quick list or into the ordered list with linking and merging,
// and no free gives a result. When nothing fits, the break grows, the new block is
// released and the whole allocate runs again; if the limit leaves no room, it fails.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_UNITS = 1024,
  parameter int unsigned QUICK_LISTS = 9,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [ffha_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ffha_pkg::RegW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic op_i,
  input  logic [ffha_pkg::NbW-1:0] nbytes_i,
  input  logic [ffha_pkg::AdrW-1:0] addr_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [ffha_pkg::AdrW-1:0] addr_res_o,
  output logic ok_o
);
  import ffha_pkg::*;
  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned DW = 2 * UW;
  localparam int unsigned QW = (QUICK_LISTS > 1) ? $clog2(QUICK_LISTS) : 1;
  localparam int unsigned SH = $clog2(UNIT_BYTES);
  localparam int unsigned WW = UW + 2;

  localparam logic [4:0] S_INIT0 = 5'd0, S_INIT1 = 5'd1, S_IDLE = 5'd2,
    S_DEC = 5'd3, S_AQ_RD = 5'd4, S_AQ_WT = 5'd5, S_AQ_WR = 5'd6,
    S_AW_RD = 5'd7, S_AW_WT = 5'd8, S_AW_EV = 5'd9, S_AW_UNL = 5'd10,
    S_AW_CARVE = 5'd11, S_GROW = 5'd12, S_RL_RD = 5'd13, S_RL_WT = 5'd14,
    S_RL_EV = 5'd15, S_RL_LNK = 5'd16, S_MG_RD = 5'd17, S_MG_WT = 5'd18,
    S_MG_RN = 5'd19, S_MG_WN = 5'd20, S_MG_EV = 5'd21, S_OUT = 5'd22,
    S_AW_PREV = 5'd23, S_AW_PWT = 5'd24, S_RL_B = 5'd25, S_RL_BWT = 5'd26,
    S_CV_RD = 5'd27, S_CV_WT = 5'd28;

  logic [4:0] st_q, st_d;
  logic [RegW-1:0] lim_q, mgrow_q;
  logic [UW-1:0] brk_q, brk_d;
  logic [UW-1:0] qh_q [QUICK_LISTS];
  logic [NbW-1:0] n_q, n_d;
  logic [UW-1:0] cur_q, cur_d, prev_q, prev_d, blk_q, blk_d, tmp_q, tmp_d;
  logic [UW-1:0] csz_q, csz_d, cnx_q, cnx_d;
  logic [AW:0] steps_q, steps_d;
  logic mflag_q, mflag_d, ret_grow_q, ret_grow_d;
  logic [AdrW-1:0] res_adr_q, res_adr_d;
  logic res_ok_q, res_ok_d, ov_q, ov_d;
  logic we, re, busy;
  logic [AW-1:0] wa, ra;
  logic [DW-1:0] wd, rd;
  logic [UW-1:0] rd_nx, rd_sz;
  logic qwe;
  logic [QW-1:0] qidx;
  logic [UW-1:0] qval;

  assign rd_nx = rd[DW-1:UW];
  assign rd_sz = rd[UW-1:0];

  ffha_hdr_mem #(.Depth(HEAP_UNITS), .AW(AW), .DW(DW)) u_mem (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(wa), .wdata_i(wd), .re_i(re),
    .raddr_i(ra), .rdata_o(rd), .busy_o(busy)
  );

  function automatic logic in_q(input logic [WW-1:0] t);
    return t >= WW'(QuickMin) && t <= WW'(QuickMin + QUICK_LISTS - 1);
  endfunction

  logic [WW-1:0] tot_blk, need, grow, limit, room;
  logic [NbW-1:0] nunits;
  assign nunits = NbW'(((nbytes_i - 1'b1) >> SH) + 1'b1);
  assign tot_blk = WW'(csz_q) + 1'b1;
  assign need = WW'(n_q) + 1'b1;
  assign grow = (need < WW'(mgrow_q)) ? WW'(mgrow_q) : need;
  assign limit = (WW'(lim_q) < WW'(HEAP_UNITS)) ? WW'(lim_q) : WW'(HEAP_UNITS);
  assign room = limit - WW'(brk_q);

  assign in_ready_o = (st_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign addr_res_o = res_adr_q;
  assign ok_o = res_ok_q;

  always_comb begin
    st_d = st_q; brk_d = brk_q; n_d = n_q; cur_d = cur_q; prev_d = prev_q;
    blk_d = blk_q; tmp_d = tmp_q; csz_d = csz_q; cnx_d = cnx_q; steps_d = steps_q;
    mflag_d = mflag_q; ret_grow_d = ret_grow_q; res_adr_d = res_adr_q;
    res_ok_d = res_ok_q; ov_d = ov_q;
    we = 1'b0; re = 1'b0; wa = '0; ra = '0; wd = '0;
    qwe = 1'b0; qidx = '0; qval = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_INIT0: if (!busy) begin
        we = 1'b1; wa = '0; wd = {UW'(1), UW'(0)}; st_d = S_INIT1;
      end
      S_INIT1: begin
        we = 1'b1; wa = AW'(1); wd = {UW'(0), UW'(InitBreak - 2)}; st_d = S_IDLE;
      end
      S_IDLE: if (in_valid_i && !ov_q) begin
        if (op_i == OpFree) begin
          if (addr_i != '0 && UW'(addr_i - 1'b1) < brk_q) begin
            blk_d = UW'(addr_i - 1'b1); ret_grow_d = 1'b0; st_d = S_RL_B;
          end
        end else if (nbytes_i == '0) begin
          res_adr_d = '0; res_ok_d = 1'b0; st_d = S_OUT;
        end else begin
          n_d = nunits; st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (in_q(need) && qh_q[QW'(need - WW'(QuickMin))] != '0) begin
          blk_d = qh_q[QW'(need - WW'(QuickMin))]; st_d = S_AQ_RD;
        end else begin
          prev_d = '0; cur_d = '0; steps_d = '0; st_d = S_AW_RD;
        end
      end
      S_AQ_RD: begin re = 1'b1; ra = AW'(blk_q); st_d = S_AQ_WT; end
      S_AQ_WT: begin
        qwe = 1'b1; qidx = QW'(need - WW'(QuickMin)); qval = rd_nx;
        we = 1'b1; wa = AW'(blk_q); wd = {UW'(0), rd_sz}; st_d = S_AQ_WR;
      end
      S_AQ_WR: begin
        res_adr_d = AdrW'(blk_q + 1'b1); res_ok_d = 1'b1; st_d = S_OUT;
      end
      S_AW_RD: begin re = 1'b1; ra = AW'(cur_q); st_d = S_AW_WT; end
      S_AW_WT: begin
        if (cur_q == '0) begin
          cur_d = rd_nx; st_d = S_AW_EV;
        end else begin
          csz_d = rd_sz; cnx_d = rd_nx; st_d = S_AW_EV;
          if (WW'(n_q) == WW'(rd_sz)) st_d = S_AW_PREV;
          else if (WW'(n_q) < WW'(rd_sz)) st_d = S_AW_CARVE;
          else begin
            prev_d = cur_q; cur_d = rd_nx; steps_d = steps_q + 1'b1;
          end
        end
      end
      S_AW_EV: begin
        if (cur_q == '0 || steps_q == (AW+1)'(HEAP_UNITS)) st_d = S_GROW;
        else st_d = S_AW_RD;
      end
      S_AW_PREV: begin re = 1'b1; ra = AW'(prev_q); st_d = S_AW_PWT; end
      S_AW_PWT: begin
        we = 1'b1; wa = AW'(prev_q); wd = {cnx_q, rd_sz}; st_d = S_AW_UNL;
      end
      S_AW_UNL: begin
        res_adr_d = AdrW'(cur_q + 1'b1); res_ok_d = 1'b1; st_d = S_OUT;
      end
      S_AW_CARVE: begin
        tmp_d = UW'(WW'(csz_q) - need);
        we = 1'b1; wa = AW'(cur_q); wd = {cnx_q, UW'(WW'(csz_q) - need)};
        st_d = S_CV_RD;
      end
      // carved tail keeps its old link, only the size changes
      S_CV_RD: begin re = 1'b1; ra = AW'(cur_q + tmp_q + 1'b1); st_d = S_CV_WT; end
      S_CV_WT: begin
        we = 1'b1; wa = AW'(cur_q + tmp_q + 1'b1); wd = {rd_nx, UW'(n_q)};
        res_adr_d = AdrW'(cur_q + tmp_q + 2'd2); res_ok_d = 1'b1; st_d = S_OUT;
      end
      S_GROW: begin
        if (WW'(brk_q) > limit || grow > room) begin
          res_adr_d = '0; res_ok_d = 1'b0; st_d = S_OUT;
        end else begin
          we = 1'b1; wa = AW'(brk_q); wd = {UW'(0), UW'(grow - 1'b1)};
          blk_d = brk_q; csz_d = UW'(grow - 1'b1); brk_d = UW'(WW'(brk_q) + grow);
          ret_grow_d = 1'b1; st_d = S_RL_EV; mflag_d = 1'b0;
        end
      end
      S_RL_B: begin re = 1'b1; ra = AW'(blk_q); st_d = S_RL_BWT; end
      S_RL_BWT: begin csz_d = rd_sz; st_d = S_RL_EV; mflag_d = 1'b0; end
      S_RL_EV: begin
        if (in_q(tot_blk)) begin
          qidx = QW'(tot_blk - WW'(QuickMin));
          qwe = 1'b1; qval = blk_q;
          we = 1'b1; wa = AW'(blk_q); wd = {qh_q[qidx], csz_q};
          st_d = ret_grow_q ? S_DEC : S_IDLE;
        end else begin
          cur_d = '0; steps_d = '0; st_d = S_RL_RD;
        end
      end
      S_RL_RD: begin
        if (!(blk_q > cur_q) || steps_q == (AW+1)'(HEAP_UNITS)) begin
          st_d = ret_grow_q ? S_DEC : S_IDLE;
        end else begin
          re = 1'b1; ra = AW'(cur_q); st_d = S_RL_WT;
        end
      end
      S_RL_WT: begin
        cnx_d = rd_nx; tmp_d = rd_sz;
        if (blk_q < rd_nx || rd_nx == '0) begin
          we = 1'b1; wa = AW'(blk_q); wd = {rd_nx, csz_q}; st_d = S_RL_LNK;
        end else begin
          cur_d = rd_nx; steps_d = steps_q + 1'b1; st_d = S_RL_RD;
        end
      end
      S_RL_LNK: begin
        we = 1'b1; wa = AW'(cur_q); wd = {blk_q, tmp_q};
        mflag_d = 1'b0; st_d = S_MG_RD;
        if (cur_q == '0) begin cur_d = blk_q; mflag_d = 1'b1; end
      end
      S_MG_RD: begin re = 1'b1; ra = AW'(cur_q); st_d = S_MG_WT; end
      S_MG_WT: begin
        csz_d = rd_sz; cnx_d = rd_nx;
        if (rd_nx != '0 && WW'(cur_q) + WW'(rd_sz) + 1'b1 == WW'(rd_nx)) begin
          st_d = S_MG_RN;
        end else begin
          st_d = S_MG_EV;
          if (!mflag_q) cur_d = rd_nx;
        end
      end
      S_MG_RN: begin re = 1'b1; ra = AW'(cnx_q); st_d = S_MG_WN; end
      S_MG_WN: begin
        we = 1'b1; wa = AW'(cur_q);
        wd = {rd_nx, UW'(WW'(csz_q) + WW'(rd_sz) + 1'b1)};
        st_d = mflag_q ? (ret_grow_q ? S_DEC : S_IDLE) : S_MG_RD;
        mflag_d = 1'b1;
      end
      S_MG_EV: begin
        if (!mflag_q) begin
          mflag_d = 1'b1; st_d = S_MG_RD;
        end else begin
          st_d = ret_grow_q ? S_DEC : S_IDLE;
        end
      end
      S_OUT: begin ov_d = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT0; brk_q <= UW'(InitBreak); lim_q <= RegW'(1024);
      mgrow_q <= RegW'(64); ov_q <= 1'b0; mflag_q <= 1'b0; ret_grow_q <= 1'b0;
      for (int i = 0; i < QUICK_LISTS; i++) qh_q[i] <= '0;
    end else begin
      st_q <= st_d; brk_q <= brk_d; ov_q <= ov_d; mflag_q <= mflag_d;
      ret_grow_q <= ret_grow_d;
      if (qwe) qh_q[qidx] <= qval;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHeapLimit) lim_q <= cfg_data_i;
        else if (cfg_idx_i == CfgMinGrow) mgrow_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; cur_q <= cur_d; prev_q <= prev_d; blk_q <= blk_d; tmp_q <= tmp_d;
    csz_q <= csz_d; cnx_q <= cnx_d; steps_q <= steps_d;
    res_adr_q <= res_adr_d; res_ok_q <= res_ok_d;
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_q == S_IDLE) else $error("ready outside idle");
  a_brk_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= UW'(HEAP_UNITS)) else $error("break past heap");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> addr_res_o == '0) else $error("failed alloc with address");
`endif
endmodule

### hw/rtl/ffha_hdr_mem.sv
// Header memory: one write port, one registered read port, reset image via fill count.
`timescale 1ns / 1ps
module ffha_hdr_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          busy_o
);
  logic [DW-1:0] mem [Depth];
  logic [AW:0] fill_q;
  logic [DW-1:0] rdata_q;

  assign busy_o = (fill_q != Depth[AW:0]);
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[fill_q[AW-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (busy_o) begin
      fill_q <= fill_q + 1'b1;
    end
  end
endmodule
